>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker modules. Each macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/xcrc_pkg.sv
// ----------------------------------------------------------------------------
// xcrc_pkg
// Types, protocol characters and the CRC-16 byte update used by the
// XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package xcrc_pkg;

  // Input item modes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT = 2'd1;
  localparam logic [1:0] MODE_START   = 2'd2;

  // Protocol characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  // Block result marks
  localparam logic [1:0] PR_NONE   = 2'd0;
  localparam logic [1:0] PR_ACCEPT = 2'd1;
  localparam logic [1:0] PR_REJECT = 2'd2;

  // Session end codes
  localparam logic [1:0] SE_RUNNING  = 2'd0;
  localparam logic [1:0] SE_EOT      = 2'd1;
  localparam logic [1:0] SE_ABORTED  = 2'd2;
  localparam logic [1:0] SE_HOST_CAN = 2'd3;

  // CRC and block constants
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [7:0]  NUM_SUM        = 8'hFF;
  localparam logic [7:0]  ERR_MAX        = 8'hFF;
  localparam logic [7:0]  MAX_ERRORS_RST = 8'd3;
  localparam logic [10:0] SHORT_SIZE     = 11'd128;
  localparam logic [10:0] LONG_SIZE      = 11'd1024;

  // Push counts into the result queue
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  // Receiver phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_HEADER = 7'b0000010,
    PH_NUMBER = 7'b0000100,
    PH_COMPL  = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CRCHI  = 7'b0100000,
    PH_CRCLO  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] packet_result;
    logic [1:0] session_end;
    logic       last;
  } out_item_t;

  // CRC-16 update by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/xcrc_out_fifo.sv
// ----------------------------------------------------------------------------
// xcrc_out_fifo
// Result queue: takes up to two result items per cycle, hands out one per
// transfer on the valid/ready output channel.
// ----------------------------------------------------------------------------
module xcrc_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_cnt,
  input  xcrc_pkg::out_item_t push_item0,
  input  xcrc_pkg::out_item_t push_item1,
  output logic                room_two,
  output logic                out_valid,
  input  logic                out_ready,
  output xcrc_pkg::out_item_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  xcrc_pkg::out_item_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room_two  = (cnt_r <= CNT_W'(DEPTH - 2));

  // Pointer and fill count update
  always_comb begin
    case (push_cnt)
      xcrc_pkg::PUSH_ONE: wr_ptr_nxt = ptr_inc(wr_ptr_r);
      xcrc_pkg::PUSH_TWO: wr_ptr_nxt = ptr_inc(ptr_inc(wr_ptr_r));
      default:            wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_cnt == xcrc_pkg::PUSH_ONE || push_cnt == xcrc_pkg::PUSH_TWO) begin
      mem[wr_ptr_r] <= push_item0;
    end
    if (push_cnt == xcrc_pkg::PUSH_TWO) begin
      mem[ptr_inc(wr_ptr_r)] <= push_item1;
    end
  end

endmodule

>>> design/xmodem_crc_receiver_top.sv
// ----------------------------------------------------------------------------
// xmodem_crc_receiver_top
// Receiver side of XMODEM-CRC with 128-byte and 1024-byte blocks.
// ----------------------------------------------------------------------------
// Each input transfer (a received byte, a timeout tick or a session start)
// is captured in an input register and handled from there once the result
// queue has room for two results: one pass of the protocol state machine,
// including a byte-wide CRC-16 update, writes zero, one or two result items
// into a small result queue. A new input is taken every cycle as long as the
// queue has room for two results, so the block sustains one input per cycle;
// results leave at one per cycle while out_ready is high, which is what
// bounds throughput when inputs cause two results (the CAN CAN abort). A
// result passes the input register and the result queue before it is offered.
// max_errors may be written only while the receiver has no work in flight.
module xmodem_crc_receiver_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  xcrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output xcrc_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  // Input register
  logic               in_vld_r;
  xcrc_pkg::in_item_t in_data_r;
  logic               room_two;
  logic               proc;

  // Protocol state
  xcrc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  max_errors_r;
  logic [7:0]  exp_num_r, exp_num_nxt;
  logic [7:0]  got_num_r, got_num_nxt;
  logic [7:0]  got_cmp_r, got_cmp_nxt;
  logic [10:0] byte_cnt_r, byte_cnt_nxt;
  logic        long_blk_r, long_blk_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [7:0]  err_cnt_r, err_cnt_nxt;
  logic        first_seen_r, first_seen_nxt;

  // Per-item combinational results
  logic [1:0]          push_cnt;
  xcrc_pkg::out_item_t item0, item1;
  logic                do_err;
  logic [1:0]          err_pr;
  logic [7:0]          err_inc;
  logic [7:0]          b;
  logic [10:0]         byte_cnt_inc;
  logic [10:0]         blk_size;
  logic                blk_ok;

  assign proc     = in_vld_r && room_two;
  assign in_ready = !in_vld_r || proc;
  assign b        = in_data_r.rx_byte;

  assign err_inc      = (err_cnt_r == xcrc_pkg::ERR_MAX) ? err_cnt_r : err_cnt_r + 8'd1;
  assign byte_cnt_inc = byte_cnt_r + 11'd1;
  assign blk_size     = long_blk_r ? xcrc_pkg::LONG_SIZE : xcrc_pkg::SHORT_SIZE;
  assign blk_ok       = (got_num_r == exp_num_r) &&
                        (8'(got_num_r + got_cmp_r) == xcrc_pkg::NUM_SUM) &&
                        (got_num_r <= 8'(xcrc_pkg::NUM_SUM - got_cmp_r)) &&
                        ({crc_hi_r, b} == crc_r);

  // Input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Protocol state machine, one input per pass
  always_comb begin
    phase_nxt      = phase_r;
    exp_num_nxt    = exp_num_r;
    got_num_nxt    = got_num_r;
    got_cmp_nxt    = got_cmp_r;
    byte_cnt_nxt   = byte_cnt_r;
    long_blk_nxt   = long_blk_r;
    crc_nxt        = crc_r;
    crc_hi_nxt     = crc_hi_r;
    err_cnt_nxt    = err_cnt_r;
    first_seen_nxt = first_seen_r;
    push_cnt       = xcrc_pkg::PUSH_NONE;
    item0          = '0;
    item1          = '0;
    do_err         = 1'b0;
    err_pr         = xcrc_pkg::PR_NONE;

    if (proc) begin
      case (in_data_r.mode)
        xcrc_pkg::MODE_START: begin
          exp_num_nxt    = 8'd1;
          err_cnt_nxt    = '0;
          first_seen_nxt = 1'b0;
          byte_cnt_nxt   = '0;
          crc_nxt        = '0;
          phase_nxt      = xcrc_pkg::PH_HEADER;
        end
        xcrc_pkg::MODE_TIMEOUT: begin
          if (phase_r == xcrc_pkg::PH_HEADER) begin
            if (!first_seen_r) begin
              item0.tx_valid = 1'b1;
              item0.tx_byte  = xcrc_pkg::CH_C;
              item0.last     = 1'b1;
              push_cnt       = xcrc_pkg::PUSH_ONE;
            end else begin
              do_err = 1'b1;
            end
          end else if (phase_r != xcrc_pkg::PH_IDLE) begin
            // timeout inside a block drops it
            do_err = 1'b1;
            err_pr = xcrc_pkg::PR_REJECT;
          end
        end
        xcrc_pkg::MODE_BYTE: begin
          case (phase_r)
            xcrc_pkg::PH_HEADER: begin
              if (b inside {xcrc_pkg::CH_SOH, xcrc_pkg::CH_STX}) begin
                long_blk_nxt = (b == xcrc_pkg::CH_STX);
                byte_cnt_nxt = '0;
                crc_nxt      = '0;
                phase_nxt    = xcrc_pkg::PH_NUMBER;
              end else if (b == xcrc_pkg::CH_EOT) begin
                item0.tx_valid    = 1'b1;
                item0.tx_byte     = xcrc_pkg::CH_ACK;
                item0.session_end = xcrc_pkg::SE_EOT;
                item0.last        = 1'b1;
                push_cnt          = xcrc_pkg::PUSH_ONE;
                phase_nxt         = xcrc_pkg::PH_IDLE;
              end else if (b == xcrc_pkg::CH_CAN) begin
                item0.session_end = xcrc_pkg::SE_HOST_CAN;
                item0.last        = 1'b1;
                push_cnt          = xcrc_pkg::PUSH_ONE;
                phase_nxt         = xcrc_pkg::PH_IDLE;
              end else begin
                do_err = 1'b1;
              end
            end
            xcrc_pkg::PH_NUMBER: begin
              got_num_nxt = b;
              phase_nxt   = xcrc_pkg::PH_COMPL;
            end
            xcrc_pkg::PH_COMPL: begin
              got_cmp_nxt = b;
              phase_nxt   = xcrc_pkg::PH_DATA;
            end
            xcrc_pkg::PH_DATA: begin
              crc_nxt      = xcrc_pkg::crc_byte(crc_r, b);
              byte_cnt_nxt = byte_cnt_inc;
              if (byte_cnt_inc >= blk_size) begin
                phase_nxt = xcrc_pkg::PH_CRCHI;
              end
              item0.data_valid = 1'b1;
              item0.data_byte  = b;
              item0.last       = 1'b1;
              push_cnt         = xcrc_pkg::PUSH_ONE;
            end
            xcrc_pkg::PH_CRCHI: begin
              crc_hi_nxt = b;
              phase_nxt  = xcrc_pkg::PH_CRCLO;
            end
            xcrc_pkg::PH_CRCLO: begin
              first_seen_nxt = 1'b1;
              if (blk_ok) begin
                exp_num_nxt         = exp_num_r + 8'd1;
                phase_nxt           = xcrc_pkg::PH_HEADER;
                item0.tx_valid      = 1'b1;
                item0.tx_byte       = xcrc_pkg::CH_ACK;
                item0.packet_result = xcrc_pkg::PR_ACCEPT;
                item0.last          = 1'b1;
                push_cnt            = xcrc_pkg::PUSH_ONE;
              end else begin
                do_err = 1'b1;
                err_pr = xcrc_pkg::PR_REJECT;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // Error handling: NAK, or CAN CAN and abort at the limit
      if (do_err) begin
        err_cnt_nxt         = err_inc;
        item0.tx_valid      = 1'b1;
        item0.packet_result = err_pr;
        if (err_inc >= max_errors_r) begin
          item0.tx_byte     = xcrc_pkg::CH_CAN;
          item1.tx_valid    = 1'b1;
          item1.tx_byte     = xcrc_pkg::CH_CAN;
          item1.session_end = xcrc_pkg::SE_ABORTED;
          item1.last        = 1'b1;
          push_cnt          = xcrc_pkg::PUSH_TWO;
          phase_nxt         = xcrc_pkg::PH_IDLE;
        end else begin
          item0.tx_byte = xcrc_pkg::CH_NAK;
          item0.last    = 1'b1;
          push_cnt      = xcrc_pkg::PUSH_ONE;
          phase_nxt     = xcrc_pkg::PH_HEADER;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= xcrc_pkg::PH_IDLE;
      max_errors_r <= xcrc_pkg::MAX_ERRORS_RST;
      exp_num_r    <= 8'd1;
      got_num_r    <= '0;
      got_cmp_r    <= '0;
      byte_cnt_r   <= '0;
      long_blk_r   <= 1'b0;
      crc_r        <= '0;
      crc_hi_r     <= '0;
      err_cnt_r    <= '0;
      first_seen_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      exp_num_r    <= exp_num_nxt;
      got_num_r    <= got_num_nxt;
      got_cmp_r    <= got_cmp_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      long_blk_r   <= long_blk_nxt;
      crc_r        <= crc_nxt;
      crc_hi_r     <= crc_hi_nxt;
      err_cnt_r    <= err_cnt_nxt;
      first_seen_r <= first_seen_nxt;
      if (cfg_wr_en) begin
        max_errors_r <= cfg_wr_data;
      end
    end
  end

  // Result queue
  xcrc_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_item0 (item0),
    .push_item1 (item1),
    .room_two   (room_two),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> design/xcrc_checker.sv
// ----------------------------------------------------------------------------
// xcrc_checker
// Port-level checks on the receiver's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xcrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input xcrc_pkg::out_item_t out_data
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // session end always closes the results of its input
  `ASSERT_IMPL(a_end_last, out_valid && out_data.session_end != xcrc_pkg::SE_RUNNING, out_data.last, "session end without last")

  // no control byte means a zero tx byte
  `ASSERT_IMPL(a_tx_zero, out_valid && !out_data.tx_valid, out_data.tx_byte == 8'h00, "tx byte set without tx valid")

  // payload bytes travel alone
  `ASSERT_IMPL(a_data_alone, out_valid && out_data.data_valid, !out_data.tx_valid && out_data.last, "payload mixed with control")

  // every block verdict is answered to the host
  `ASSERT_IMPL(a_result_tx, out_valid && out_data.packet_result != xcrc_pkg::PR_NONE, out_data.tx_valid, "block verdict without answer")

endmodule

bind xmodem_crc_receiver_top xcrc_checker u_xcrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/tb_xmodem_crc_receiver_top.sv
// ----------------------------------------------------------------------------
// tb_xmodem_crc_receiver_top
// Self-checking bench for the XMODEM-CRC receiver. Feeds received bytes,
// timeout ticks and session starts through the input channel. A behavioral
// predictor tracks the receiver's phase, block number, CRC-16 and error count
// and queues the expected result items, which are checked in order against
// the result channel. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_xmodem_crc_receiver_top;
  import xcrc_pkg::*;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         RANDOM_ITEMS  = 1100;
  localparam int         DRAIN_CYCLES  = 8;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic [7:0] cfg_wr_data;

  xmodem_crc_receiver_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Receiver state as the bench sees it
  phase_t      rx_phase;
  logic [7:0]  max_err_limit;
  logic [7:0]  next_block_num;
  logic [7:0]  hdr_num;
  logic [7:0]  hdr_cmp;
  logic [10:0] data_count;
  logic        long_blk;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi;
  logic [7:0]  err_cnt;
  logic        block_seen;

  out_item_t pending_responses[$];

  // Bookkeeping
  int  mismatch_count  = 0;
  int  results_checked = 0;
  int  active_items    = 0;
  int  blocks_acked    = 0;
  int  blocks_rejected = 0;
  int  aborts_seen     = 0;
  int  cfg_writes      = 0;
  int  cycle_count     = 0;
  bit  in_idle_on      = 1'b1;
  bit  out_idle_on     = 1'b1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void add_expected(input logic txv, input logic [7:0] txb,
                                       input logic dv, input logic [7:0] db,
                                       input logic [1:0] pr, input logic [1:0] se,
                                       input logic fin);
    out_item_t r;
    r.tx_valid      = txv;
    r.tx_byte       = txb;
    r.data_valid    = dv;
    r.data_byte     = db;
    r.packet_result = pr;
    r.session_end   = se;
    r.last          = fin;
    pending_responses.push_back(r);
  endfunction

  function automatic void reset_receiver_state();
    rx_phase       = PH_IDLE;
    max_err_limit  = MAX_ERRORS_RST;
    next_block_num = 8'd1;
    hdr_num        = '0;
    hdr_cmp        = '0;
    data_count     = '0;
    long_blk       = 1'b0;
    crc_acc        = '0;
    crc_hi         = '0;
    err_cnt        = '0;
    block_seen     = 1'b0;
  endfunction

  // One error: NAK, or CAN CAN and abort once the limit is reached
  function automatic void book_error(input logic [1:0] pr);
    if (err_cnt != ERR_MAX) begin
      err_cnt = err_cnt + 8'd1;
    end
    if (err_cnt >= max_err_limit) begin
      add_expected(1'b1, CH_CAN, 1'b0, 8'h00, pr, SE_RUNNING, 1'b0);
      add_expected(1'b1, CH_CAN, 1'b0, 8'h00, PR_NONE, SE_ABORTED, 1'b1);
      rx_phase = PH_IDLE;
      aborts_seen++;
    end else begin
      add_expected(1'b1, CH_NAK, 1'b0, 8'h00, pr, SE_RUNNING, 1'b1);
      rx_phase = PH_HEADER;
    end
  endfunction

  // Expected results of one accepted input transfer
  function automatic void predict_response(input in_item_t it);
    logic [10:0] blk_size;
    logic [15:0] rx_crc;
    logic        ok;
    if (it.mode == MODE_START) begin
      next_block_num = 8'd1;
      err_cnt        = '0;
      block_seen     = 1'b0;
      data_count     = '0;
      crc_acc        = '0;
      rx_phase       = PH_HEADER;
      active_items++;
      return;
    end
    if (it.mode == MODE_RESERVED || rx_phase == PH_IDLE) begin
      return;
    end
    active_items++;

    // Timeout tick: 'C' while waiting for the first block, else an error
    if (it.mode == MODE_TIMEOUT) begin
      if (rx_phase == PH_HEADER) begin
        if (!block_seen) begin
          add_expected(1'b1, CH_C, 1'b0, 8'h00, PR_NONE, SE_RUNNING, 1'b1);
        end else begin
          book_error(PR_NONE);
        end
      end else begin
        book_error(PR_REJECT);
      end
      return;
    end

    case (rx_phase)
      PH_HEADER: begin
        if (it.rx_byte == CH_SOH || it.rx_byte == CH_STX) begin
          long_blk   = (it.rx_byte == CH_STX);
          data_count = '0;
          crc_acc    = '0;
          rx_phase   = PH_NUMBER;
        end else if (it.rx_byte == CH_EOT) begin
          add_expected(1'b1, CH_ACK, 1'b0, 8'h00, PR_NONE, SE_EOT, 1'b1);
          rx_phase = PH_IDLE;
        end else if (it.rx_byte == CH_CAN) begin
          add_expected(1'b0, 8'h00, 1'b0, 8'h00, PR_NONE, SE_HOST_CAN, 1'b1);
          rx_phase = PH_IDLE;
        end else begin
          book_error(PR_NONE);
        end
      end
      PH_NUMBER: begin
        hdr_num  = it.rx_byte;
        rx_phase = PH_COMPL;
      end
      PH_COMPL: begin
        hdr_cmp  = it.rx_byte;
        rx_phase = PH_DATA;
      end
      PH_DATA: begin
        blk_size   = long_blk ? LONG_SIZE : SHORT_SIZE;
        crc_acc    = crc16_step(crc_acc, it.rx_byte);
        data_count = data_count + 11'd1;
        if (data_count >= blk_size) begin
          rx_phase = PH_CRCHI;
        end
        add_expected(1'b0, 8'h00, 1'b1, it.rx_byte, PR_NONE, SE_RUNNING, 1'b1);
      end
      PH_CRCHI: begin
        crc_hi   = it.rx_byte;
        rx_phase = PH_CRCLO;
      end
      default: begin
        rx_crc     = {crc_hi, it.rx_byte};
        ok         = (hdr_num == next_block_num) &&
                     ({1'b0, hdr_num} + {1'b0, hdr_cmp} == {1'b0, NUM_SUM}) &&
                     (rx_crc == crc_acc);
        block_seen = 1'b1;
        if (ok) begin
          next_block_num = next_block_num + 8'd1;
          rx_phase       = PH_HEADER;
          blocks_acked++;
          add_expected(1'b1, CH_ACK, 1'b0, 8'h00, PR_ACCEPT, SE_RUNNING, 1'b1);
        end else begin
          blocks_rejected++;
          book_error(PR_REJECT);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and result-side stalls
  // ---------------------------------------------------------------------------

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("tx %0b/%02h data %0b/%02h pr %0d se %0d last %0b",
                     r.tx_valid, r.tx_byte, r.data_valid, r.data_byte,
                     r.packet_result, r.session_end, r.last);
  endfunction

  function automatic void log_mismatch(input string why, input out_item_t e,
                                       input out_item_t a);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH at cycle %0d (%s): expected %s, got %s",
               cycle_count, why, fmt_result(e), fmt_result(a));
    end
  endfunction

  initial begin : result_checker
    out_item_t act;
    out_item_t exp_r;
    int        stall;
    bit        took;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      // Sample between edges; the transfer happens at the following rising edge
      @(negedge clk);
      took = rst_n && out_valid && out_ready;
      if (took) begin
        act = out_data;
        if (pending_responses.size() == 0) begin
          log_mismatch("no result expected", '0, act);
        end else begin
          exp_r = pending_responses.pop_front();
          results_checked++;
          if (act.tx_valid !== exp_r.tx_valid || act.tx_byte !== exp_r.tx_byte ||
              act.data_valid !== exp_r.data_valid || act.data_byte !== exp_r.data_byte ||
              act.packet_result !== exp_r.packet_result ||
              act.session_end !== exp_r.session_end || act.last !== exp_r.last) begin
            log_mismatch("field differs", exp_r, act);
          end
        end
      end
      @(posedge clk);
      if (took) begin
        stall = out_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transfer; valid stays high afterwards until the next call or a pause
  task automatic send_item(input logic [1:0] mode, input logic [7:0] value);
    in_item_t item;
    int       gap;
    item.mode    = mode;
    item.rx_byte = value;
    gap = in_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
    end while (!in_ready);
    @(posedge clk);
    predict_response(item);
  endtask

  // Stop sending and wait until every expected result has been taken
  task automatic settle_receiver();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_errors(input logic [7:0] value);
    settle_receiver();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    max_err_limit = value;
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  // Full block: header, number, complement, payload, CRC (optionally corrupted)
  task automatic send_block(input logic [7:0] hdr, input logic [7:0] num,
                            input logic [7:0] cmp, input fill_t fill, input bit bad_crc);
    int          size;
    logic [7:0]  d;
    logic [15:0] crc;
    size = (hdr == CH_STX) ? 1024 : 128;
    crc  = '0;
    send_item(MODE_BYTE, hdr);
    send_item(MODE_BYTE, num);
    send_item(MODE_BYTE, cmp);
    for (int i = 0; i < size; i++) begin
      case (fill)
        FILL_ZERO: d = 8'h00;
        FILL_ONES: d = 8'hFF;
        default:   d = 8'($urandom_range(0, 255));
      endcase
      crc = crc16_step(crc, d);
      send_item(MODE_BYTE, d);
    end
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_item(MODE_BYTE, crc[15:8]);
    send_item(MODE_BYTE, crc[7:0]);
  endtask

  task automatic send_good_block(input logic [7:0] hdr, input fill_t fill);
    send_block(hdr, next_block_num, ~next_block_num, fill, 1'b0);
  endtask

  // Header plus n random bytes, then a timeout drops the block
  task automatic send_cut_block(input logic [7:0] hdr, input int n);
    send_item(MODE_BYTE, hdr);
    repeat (n) send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
    send_item(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] bad_header_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_SOH || b == CH_STX || b == CH_EOT || b == CH_CAN);
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No session running: everything is dropped silently
  task automatic test_ignored_when_idle();
    send_item(MODE_BYTE, CH_SOH);
    send_item(MODE_BYTE, CH_STX);
    send_item(MODE_BYTE, CH_EOT);
    send_item(MODE_BYTE, CH_CAN);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_TIMEOUT, 8'h00);
    send_item(MODE_RESERVED, 8'hFF);
  endtask

  // 'C' polling, unused mode, host cancel, restart, EOT before any block
  task automatic test_poll_and_host_cancel();
    send_item(MODE_START, 8'h00);
    send_item(MODE_TIMEOUT, 8'hFF);
    send_item(MODE_TIMEOUT, 8'h00);
    send_item(MODE_RESERVED, CH_SOH);
    send_item(MODE_BYTE, CH_CAN);
    send_item(MODE_START, 8'hFF);
    send_item(MODE_START, 8'h55);
    send_item(MODE_BYTE, CH_EOT);
  endtask

  // Accepted 128-byte blocks with extreme payloads, then a clean end
  task automatic test_good_short_blocks();
    send_item(MODE_START, 8'h00);
    send_item(MODE_TIMEOUT, 8'h00);
    send_good_block(CH_SOH, FILL_ZERO);
    send_good_block(CH_SOH, FILL_ONES);
    send_good_block(CH_SOH, FILL_RANDOM);
    send_item(MODE_TIMEOUT, 8'h00);
    send_item(MODE_BYTE, CH_EOT);
  endtask

  // Every way a block can be turned down, with a limit high enough to keep going
  task automatic test_block_rejects();
    write_max_errors(8'd255);
    send_item(MODE_START, 8'h00);
    send_item(MODE_TIMEOUT, 8'h00);
    send_block(CH_SOH, 8'h00, 8'hFF, FILL_RANDOM, 1'b0);   // wrong number
    send_block(CH_SOH, 8'h01, 8'h00, FILL_RANDOM, 1'b0);   // bad complement
    send_block(CH_SOH, 8'h01, 8'hFE, FILL_RANDOM, 1'b1);   // bad CRC
    send_item(MODE_TIMEOUT, 8'h00);                        // still before first good block
    send_good_block(CH_SOH, FILL_RANDOM);
    send_block(CH_SOH, 8'h01, 8'hFE, FILL_RANDOM, 1'b0);   // repeated block number
    send_block(CH_SOH, 8'hFF, 8'h00, FILL_RANDOM, 1'b0);
    send_item(MODE_TIMEOUT, 8'h00);                        // header timeout is an error now
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, CH_ACK);
    // Timeouts in each phase of a block
    send_cut_block(CH_SOH, 0);
    send_cut_block(CH_SOH, 1);
    send_cut_block(CH_SOH, 2);
    send_cut_block(CH_SOH, 130);
    send_cut_block(CH_SOH, 131);
    send_cut_block(CH_STX, 5);
    // Unused mode inside a block, then a restart in the middle of it
    send_item(MODE_BYTE, CH_SOH);
    send_item(MODE_BYTE, 8'h02);
    send_item(MODE_RESERVED, 8'h00);
    send_item(MODE_BYTE, 8'hFD);
    send_item(MODE_BYTE, 8'hA5);
    send_item(MODE_START, 8'h00);
    send_good_block(CH_SOH, FILL_RANDOM);
    send_item(MODE_BYTE, CH_EOT);
  endtask

  // Abort at the error limit for several limit settings
  task automatic test_error_limits();
    write_max_errors(8'd1);
    send_item(MODE_START, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, CH_SOH);
    send_item(MODE_TIMEOUT, 8'h00);

    // Zero limit: first error aborts; polling is not an error
    write_max_errors(8'd0);
    send_item(MODE_START, 8'h00);
    send_item(MODE_TIMEOUT, 8'h00);
    send_item(MODE_BYTE, CH_SOH);
    send_item(MODE_TIMEOUT, 8'h00);

    // Header timeouts after the first block count toward the limit
    write_max_errors(8'd2);
    send_item(MODE_START, 8'h00);
    send_good_block(CH_SOH, FILL_RANDOM);
    send_item(MODE_TIMEOUT, 8'h00);
    send_item(MODE_TIMEOUT, 8'h00);

    // Largest limit: 254 NAKs, abort on the 255th error
    write_max_errors(8'd255);
    send_item(MODE_START, 8'h00);
    repeat (255) send_item(MODE_BYTE, bad_header_byte());
    write_max_errors(MAX_ERRORS_RST);
  endtask

  // One 1024-byte block sent without idling on either side, then a 128-byte block and EOT
  task automatic test_long_block();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_item(MODE_START, 8'h00);
    send_good_block(CH_STX, FILL_RANDOM);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    send_good_block(CH_SOH, FILL_RANDOM);
    send_item(MODE_BYTE, CH_EOT);
  endtask

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(2, 6));
    endcase
  endfunction

  // One block slot of a random session: well formed in 7 of 16 draws, otherwise broken
  task automatic send_random_block();
    logic [7:0] num;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6: send_good_block(CH_SOH, FILL_RANDOM);
      7: begin
        num = next_block_num + 8'($urandom_range(1, 255));
        send_block(CH_SOH, num, ~num, FILL_RANDOM, 1'b0);
      end
      8: send_block(CH_SOH, next_block_num,
                    ~next_block_num ^ (8'h01 << $urandom_range(0, 7)), FILL_RANDOM, 1'b0);
      9:  send_block(CH_SOH, next_block_num, ~next_block_num, FILL_RANDOM, 1'b1);
      10: send_block(CH_SOH, next_block_num - 8'd1, ~(next_block_num - 8'd1),
                     FILL_RANDOM, 1'b0);
      11: send_cut_block(CH_SOH, $urandom_range(0, 131));
      12: send_cut_block(CH_STX, $urandom_range(0, 12));
      13: send_item(MODE_BYTE, bad_header_byte());
      14: send_item(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(MODE_RESERVED, 8'($urandom_range(0, 255)));
        end else begin
          send_item(MODE_START, 8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  task automatic test_random_sessions();
    int start_items;
    int session;
    int blocks;
    start_items = active_items;
    session     = 0;
    while (active_items - start_items < RANDOM_ITEMS) begin
      session++;
      // New limit every other session; otherwise sometimes hold off until drained
      if (session % 2 == 0) begin
        write_max_errors(pick_limit());
      end else if ($urandom_range(0, 2) == 0) begin
        settle_receiver();
      end
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      send_item(MODE_START, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) send_item(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
      blocks = $urandom_range(1, 3);
      for (int k = 0; k < blocks && rx_phase != PH_IDLE; k++) begin
        send_random_block();
      end
      if (rx_phase != PH_IDLE) begin
        case ($urandom_range(0, 5))
          0:       send_item(MODE_BYTE, CH_CAN);
          1:       ;
          default: send_item(MODE_BYTE, CH_EOT);
        endcase
      end
      // Trailing noise, mostly landing on an idle receiver
      repeat ($urandom_range(0, 2)) begin
        send_item($urandom_range(0, 1) ? MODE_TIMEOUT : MODE_BYTE,
                  8'($urandom_range(0, 255)));
      end
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    reset_receiver_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_when_idle();
    test_poll_and_host_cancel();
    test_good_short_blocks();
    test_block_rejects();
    test_error_limits();
    test_long_block();
    test_random_sessions();

    settle_receiver();
    repeat (12) @(posedge clk);

    $display("Covered %0d acted-on inputs and %0d checked results over %0d limit writes",
             active_items, results_checked, cfg_writes);
    $display("Blocks acked %0d, rejected %0d, aborts %0d, result errors %0d",
             blocks_acked, blocks_rejected, aborts_seen, mismatch_count);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
